// ===== hdl/tfpq_pkg.sv =====
// Shared constants, codes, types and helpers of the transmit frame pointer queue.
package tfpq_pkg;

  // Queue geometry and field widths.
  localparam int QUEUE_DEPTH = 14;
  localparam int PTR_W       = 16;
  localparam int LEN_W       = 15;
  localparam int ACT_W       = 2;
  localparam int STAT_W      = 2;
  localparam int FQ_W        = 4;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;
  localparam int REG_IDX_W   = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BUFFER_BYTES = REG_IDX_W'(0);
  localparam logic [LEN_W-1:0]     BUFFER_BYTES_RESET = LEN_W'(16384);

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_SUBMIT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SENT   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LINK   = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_LINK_DOWN = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_ROOM   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;        // an input beat is taken and executed this cycle
    logic fetch_done;  // read data for the next send is available
  } tfpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_fetch;  // the offered beat needs the next end pointer from memory
  } tfpq_stat_t;

  // Ring index increment with wrap at the queue depth.
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    nxt = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    return nxt;
  endfunction

endpackage

// ===== hdl/tfpq_in_if.sv =====
// Input channel: one beat carries one action with its arguments.
interface tfpq_in_if;
  logic                          valid;
  logic                          ready;
  logic [tfpq_pkg::ACT_W-1:0]    action;
  logic [tfpq_pkg::LEN_W-1:0]    frame_len;
  logic                          link_state;

  modport source (output valid, action, frame_len, link_state, input ready);
  modport sink   (input valid, action, frame_len, link_state, output ready);
endinterface

// ===== hdl/tfpq_out_if.sv =====
// Output channel: one beat carries the result of one action.
interface tfpq_out_if;
  logic                          valid;
  logic                          ready;
  logic [tfpq_pkg::STAT_W-1:0]   status;
  logic [tfpq_pkg::PTR_W-1:0]    write_start;
  logic                          issue_send;
  logic [tfpq_pkg::PTR_W-1:0]    send_end_pointer;
  logic [tfpq_pkg::FQ_W-1:0]     frames_queued;

  modport source (output valid, status, write_start, issue_send, send_end_pointer,
                  frames_queued, input ready);
  modport sink   (input valid, status, write_start, issue_send, send_end_pointer,
                  frames_queued, output ready);
endinterface

// ===== hdl/tfpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tfpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tfpq_ctrl.sv =====
// Controller: sequences execute and fetch cycles and owns the output valid flag.
module tfpq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tfpq_pkg::tfpq_stat_t stat,
  output tfpq_pkg::tfpq_cmd_t  cmd
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  // A new beat is taken when idle and the output register is free or draining.
  assign in_ready       = (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.exec       = in_valid && in_ready;
  assign cmd.fetch_done = (state == S_FETCH);

  // Next state and output valid.
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (cmd.exec) begin
          if (stat.need_fetch) begin
            state_next     = S_FETCH;
            out_valid_next = 1'b0;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      S_FETCH: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b1;
      end
      default: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hdl/tfpq_dp.sv =====
// Datapath: pointer registers, end pointer ring, room check and result register.
module tfpq_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tfpq_pkg::tfpq_cmd_t           cmd,
  output tfpq_pkg::tfpq_stat_t          stat,
  input  logic [tfpq_pkg::ACT_W-1:0]    action,
  input  logic [tfpq_pkg::LEN_W-1:0]    frame_len,
  input  logic                          link_state,
  input  logic                          cfg_we,
  input  logic [tfpq_pkg::LEN_W-1:0]    cfg_wdata,
  output logic [tfpq_pkg::LEN_W-1:0]    buffer_bytes,
  output logic [tfpq_pkg::STAT_W-1:0]   status,
  output logic [tfpq_pkg::PTR_W-1:0]    write_start,
  output logic                          issue_send,
  output logic [tfpq_pkg::PTR_W-1:0]    send_end_pointer,
  output logic [tfpq_pkg::FQ_W-1:0]     frames_queued
);

  // Queue state: start of the frame in flight, last end pointer, cached head end.
  logic [tfpq_pkg::PTR_W-1:0] start_ptr;
  logic [tfpq_pkg::PTR_W-1:0] last_ptr;
  logic [tfpq_pkg::PTR_W-1:0] head_end;
  logic [tfpq_pkg::IDX_W-1:0] head;
  logic [tfpq_pkg::IDX_W-1:0] tail;
  logic [tfpq_pkg::CNT_W-1:0] count;
  logic                       link_up;

  logic [tfpq_pkg::PTR_W-1:0] used;
  logic [tfpq_pkg::PTR_W:0]   need;
  logic [tfpq_pkg::PTR_W-1:0] new_end;
  logic                       full;
  logic                       room_ok;
  logic                       do_push;
  logic                       do_pop;
  logic [tfpq_pkg::PTR_W-1:0] ram_rdata;

  logic [tfpq_pkg::STAT_W-1:0] status_next;
  logic [tfpq_pkg::PTR_W-1:0]  write_start_next;
  logic                        issue_send_next;
  logic [tfpq_pkg::PTR_W-1:0]  send_end_pointer_next;
  logic [tfpq_pkg::FQ_W-1:0]   frames_queued_next;

  // Room check: bytes in use plus the new frame against the buffer size.
  assign used    = last_ptr - start_ptr;
  assign need    = {1'b0, used} + (tfpq_pkg::PTR_W + 1)'(frame_len);
  assign new_end = last_ptr + tfpq_pkg::PTR_W'(frame_len);
  assign full    = (count >= tfpq_pkg::CNT_W'(tfpq_pkg::QUEUE_DEPTH));
  assign room_ok = !full && (need <= (tfpq_pkg::PTR_W + 1)'(buffer_bytes));

  assign do_push = cmd.exec && (action == tfpq_pkg::ACT_SUBMIT) && link_up && room_ok;
  assign do_pop  = cmd.exec && (action == tfpq_pkg::ACT_SENT) && (count != '0);

  // A pop that leaves frames behind must read the next end pointer.
  assign stat.need_fetch = (action == tfpq_pkg::ACT_SENT) &&
                           (count > tfpq_pkg::CNT_W'(1));

  // End pointer ring, one entry per queued frame.
  tfpq_ram #(
    .WIDTH (tfpq_pkg::PTR_W),
    .DEPTH (tfpq_pkg::QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (do_push),
    .waddr (tail),
    .wdata (new_end),
    .re    (do_pop && stat.need_fetch),
    .raddr (tfpq_pkg::next_idx(head)),
    .rdata (ram_rdata)
  );

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes <= tfpq_pkg::BUFFER_BYTES_RESET;
    end else if (cfg_we) begin
      buffer_bytes <= cfg_wdata;
    end
  end

  // Queue control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_ptr <= '0;
      last_ptr  <= '0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      link_up   <= 1'b0;
    end else if (cmd.exec) begin
      if (do_push) begin
        last_ptr <= new_end;
        tail     <= tfpq_pkg::next_idx(tail);
        count    <= count + tfpq_pkg::CNT_W'(1);
      end
      if (do_pop) begin
        start_ptr <= head_end;
        head      <= tfpq_pkg::next_idx(head);
        count     <= count - tfpq_pkg::CNT_W'(1);
      end
      if (action == tfpq_pkg::ACT_LINK) begin
        link_up <= link_state;
      end
    end
  end

  // Cached end pointer of the frame now being sent.
  always_ff @(posedge clk) begin
    if (do_push && (count == '0)) begin
      head_end <= new_end;
    end else if (cmd.fetch_done) begin
      head_end <= ram_rdata;
    end
  end

  // Result values of the beat executed this cycle.
  always_comb begin
    status_next           = tfpq_pkg::ST_OK;
    write_start_next      = '0;
    issue_send_next       = 1'b0;
    send_end_pointer_next = '0;
    frames_queued_next    = tfpq_pkg::FQ_W'(count);
    if (action == tfpq_pkg::ACT_SUBMIT) begin
      if (!link_up) begin
        status_next = tfpq_pkg::ST_LINK_DOWN;
      end else if (!room_ok) begin
        status_next = tfpq_pkg::ST_NO_ROOM;
      end else begin
        write_start_next   = last_ptr;
        frames_queued_next = tfpq_pkg::FQ_W'(count + tfpq_pkg::CNT_W'(1));
        if (count == '0) begin
          issue_send_next       = 1'b1;
          send_end_pointer_next = new_end;
        end
      end
    end else if (do_pop) begin
      frames_queued_next = tfpq_pkg::FQ_W'(count - tfpq_pkg::CNT_W'(1));
    end
  end

  // Result register: loaded on execute, send fields completed after a fetch.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status           <= status_next;
      write_start      <= write_start_next;
      issue_send       <= issue_send_next;
      send_end_pointer <= send_end_pointer_next;
      frames_queued    <= frames_queued_next;
    end else if (cmd.fetch_done) begin
      issue_send       <= 1'b1;
      send_end_pointer <= ram_rdata;
    end
  end

endmodule

// ===== hdl/tx_frame_pointer_queue.sv =====
// Top level of the transmit frame pointer queue.
//
//   port     | dir | payload                                                   | accepted when
//   in_ch    | in  | action, frame_len, link_state                             | valid && ready
//   out_ch   | out | status, write_start, issue_send, send_end_pointer, frames | valid && ready
//   APB      | in  | buffer_bytes at byte address 0                            | psel, penable, pwrite
//
// Most actions are executed on acceptance of the beat and their result lands in the
// output register. A send-complete that leaves frames queued goes on to a fetch state,
// because the next end pointer comes from the registered read of the pointer ring.
// A new input beat is taken while the previous result is being delivered.
// Reset (rst, synchronous) empties the queue, marks the link down and sets the
// buffer size to 16384; the ring itself needs no clearing.
module tx_frame_pointer_queue (
  input  logic                          clk,
  input  logic                          rst,
  tfpq_in_if.sink                       in_ch,
  tfpq_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tfpq_pkg::ADDR_W-1:0]   paddr,
  input  logic [tfpq_pkg::DATA_W-1:0]   pwdata,
  output logic [tfpq_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  tfpq_pkg::tfpq_cmd_t            cmd;
  tfpq_pkg::tfpq_stat_t           stat;
  logic [tfpq_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_we;
  logic [tfpq_pkg::LEN_W-1:0]     buffer_bytes;

  // Register decode.
  assign pready  = 1'b1;
  assign reg_idx = paddr[tfpq_pkg::ADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && (reg_idx == tfpq_pkg::REG_BUFFER_BYTES);
  assign prdata  = (reg_idx == tfpq_pkg::REG_BUFFER_BYTES) ?
                   tfpq_pkg::DATA_W'(buffer_bytes) : '0;

  tfpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tfpq_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .action           (in_ch.action),
    .frame_len        (in_ch.frame_len),
    .link_state       (in_ch.link_state),
    .cfg_we           (cfg_we),
    .cfg_wdata        (pwdata[tfpq_pkg::LEN_W-1:0]),
    .buffer_bytes     (buffer_bytes),
    .status           (out_ch.status),
    .write_start      (out_ch.write_start),
    .issue_send       (out_ch.issue_send),
    .send_end_pointer (out_ch.send_end_pointer),
    .frames_queued    (out_ch.frames_queued)
  );

endmodule

// ===== hdl/tfpq_checker.sv =====
// Port-level checks of the transmit frame pointer queue, bound to the top level.
module tfpq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tfpq_pkg::STAT_W-1:0] status,
  input logic [tfpq_pkg::PTR_W-1:0]  write_start,
  input logic                        issue_send,
  input logic [tfpq_pkg::FQ_W-1:0]   frames_queued
);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A refused submit neither reports a start pointer nor issues a send.
  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != tfpq_pkg::ST_OK) |-> (write_start == '0) && !issue_send)
    else $error("refused submit carries pointer or send");

  // A send is issued only with at least one frame queued.
  a_send_has_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && issue_send |-> (frames_queued != '0))
    else $error("send issued with empty queue");

  // The queue never reports more frames than it holds.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frames_queued <= tfpq_pkg::FQ_W'(tfpq_pkg::QUEUE_DEPTH)))
    else $error("frame count beyond queue depth");

endmodule

bind tx_frame_pointer_queue tfpq_checker u_tfpq_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .write_start   (out_ch.write_start),
  .issue_send    (out_ch.issue_send),
  .frames_queued (out_ch.frames_queued)
);
